/* design/sha_pkg.sv */
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int QueueDepth = 4;
    localparam int WordCount  = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_EMIT
    } back_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* design/sha_front.sv */
// Input beat queue; decouples the byte stream from the compression engine.
module sha_front #(
    parameter int DEPTH = sha_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sha_pkg::beat_t  in_beat,
    input  logic            in_push,
    output logic            in_full,
    output sha_pkg::beat_t  out_beat,
    output logic            out_valid,
    input  logic            out_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::beat_t mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign in_full   = (cnt_reg == (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_beat  = mem[rd_reg];
    assign do_push   = in_push && !in_full;
    assign do_pop    = out_take && out_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= in_beat;
        end
    end
endmodule

/* design/sha_back.sv */
// Block buffer, padding and one-round-per-cycle compression; emits digest words.
module sha_back (
    input  logic            clk,
    input  logic            rst_n,
    input  sha_pkg::beat_t  in_beat,
    input  logic            in_valid,
    output logic            in_take,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word,
    output logic            empty,
    input  logic            pop
);
    sha_pkg::back_state_t state_reg, state_next;

    logic [31:0] w_reg [16];          // schedule window, w[0] is current word
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic        pad_done_reg;        // 0x80 already placed in an earlier block
    logic        end_pend_reg;        // message ended on a full block, pad next
    logic        final_reg;           // current compression is the last one
    logic [2:0]  idx_reg;

    logic        take_byte, end_now, last_rnd;
    logic [31:0] t1, t2, s0, s1, w_new;
    logic [5:0]  fill_inc;

    assign in_take  = (state_reg == sha_pkg::ST_IDLE) && in_valid;
    assign take_byte = in_take && in_beat.byte_valid;
    assign fill_inc = fill_reg + 6'd1;
    assign last_rnd = (rnd_reg == 6'd63);

    assign s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];

    assign t1 = v_reg[7]
              + (sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                 ^ sha_pkg::rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha_pkg::round_k(rnd_reg) + w_reg[0];
    assign t2 = (sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
                 ^ sha_pkg::rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign end_now = in_take && in_beat.message_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (take_byte && fill_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ROUND;
                end
                else if (end_now)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (last_rnd)
                begin
                    state_next = final_reg ? sha_pkg::ST_EMIT :
                                 ((pad_done_reg || end_pend_reg) ? sha_pkg::ST_PAD :
                                  sha_pkg::ST_IDLE);
                end
            end
            sha_pkg::ST_PAD:
            begin
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT:
            begin
                if (pop && idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        empty       = (state_reg != sha_pkg::ST_EMIT);
        digest_word = h_reg[idx_reg];
        word_index  = idx_reg;
        last_word   = (idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            rnd_reg      <= '0;
            pad_done_reg <= 1'b0;
            end_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
            idx_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (take_byte)
                    begin
                        fill_reg <= fill_inc;
                        bits_reg <= bits_reg + 64'd8;
                    end
                    if (take_byte && fill_reg == 6'd63)
                    begin
                        rnd_reg      <= '0;
                        pad_done_reg <= 1'b0;
                        final_reg    <= 1'b0;
                        // end on a full block: pad in a fresh block afterwards
                        end_pend_reg <= in_beat.message_end;
                    end
                end
                sha_pkg::ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (last_rnd)
                    begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        for (int i = 1; i < 8; i++)
                        begin
                            if (i != 4)
                            begin
                                h_reg[i] <= h_reg[i] + v_reg[i-1];
                            end
                        end
                        fill_reg <= '0;
                        idx_reg  <= '0;
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    rnd_reg      <= '0;
                    end_pend_reg <= 1'b0;
                    if (!pad_done_reg && fill_reg >= 6'd56)
                    begin
                        pad_done_reg <= 1'b1;
                        final_reg    <= 1'b0;
                    end
                    else
                    begin
                        final_reg <= 1'b1;
                    end
                end
                sha_pkg::ST_EMIT:
                begin
                    if (pop)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            fill_reg     <= '0;
                            bits_reg     <= '0;
                            pad_done_reg <= 1'b0;
                            final_reg    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::init_h(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (state_reg == sha_pkg::ST_IDLE && take_byte)
        begin
            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= in_beat.data_byte;
            if (fill_reg == 6'd63)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
        else if (state_reg == sha_pkg::ST_PAD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (pad_done_reg || (6'(4*i+b) > fill_reg))
                    begin
                        w_reg[i][8*(3-b) +: 8] <= 8'h00;
                    end
                    else if (6'(4*i+b) == fill_reg)
                    begin
                        w_reg[i][8*(3-b) +: 8] <= 8'h80;
                    end
                end
            end
            if (pad_done_reg || fill_reg < 6'd56)
            begin
                w_reg[14] <= bits_reg[63:32];
                w_reg[15] <= bits_reg[31:0];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == sha_pkg::ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end
endmodule

/* design/sha256_stream_hasher_unit.sv */
// SHA-256 over a byte stream. Push one beat per byte (byte_valid) and mark the
// final beat with message_end; after padding and the last compression the
// eight digest words come out in order on the result side, word_index 0 first,
// last_word on the eighth. Each full 64-byte block holds the compression
// engine for its 64 rounds (one round per cycle), during which the four-beat
// input queue keeps taking beats until it is full. Ending a message costs one
// or two further compressions before the digest appears.
// The hash state returns to the initial values once the last word is popped.
module sha256_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    input  logic        push,
    output logic        full,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        empty,
    input  logic        pop
);
    sha_pkg::beat_t in_beat, q_beat;
    logic           q_valid, q_take;

    assign in_beat.data_byte   = data_byte;
    assign in_beat.byte_valid  = byte_valid;
    assign in_beat.message_end = message_end;

    // front: beat queue
    sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .in_push   (push),
        .in_full   (full),
        .out_beat  (q_beat),
        .out_valid (q_valid),
        .out_take  (q_take)
    );

    // back: block assembly, padding, compression, digest output
    sha_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_beat     (q_beat),
        .in_valid    (q_valid),
        .in_take     (q_take),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );
endmodule
